### rtl/core/tlbpt_pkg.sv
`default_nettype none
package tlbpt_pkg;
  localparam int TlbEntries = 16;
  localparam int FrameCount = 128;
  localparam int PageCount  = 256;
  localparam int VaWidth    = 16;
  localparam int PageWidth  = 8;
  localparam int OffWidth   = 8;
  localparam int FrameWidth = 7;
  localparam int PaWidth    = 15;

  // Request handed from the front end to the back end.
  typedef struct packed {
    logic [PageWidth-1:0]  page;
    logic [OffWidth-1:0]   offset;
    logic [FrameWidth-1:0] victim;
  } req_t;

  typedef enum logic [1:0] {
    BeIdle,
    BeRead,
    BeResolve,
    BeOut
  } be_state_e;
endpackage
`default_nettype wire

### rtl/core/tlbpt_front.sv
`default_nettype none
// Accepts items, reduces the page number and holds them in a two-entry queue.
module tlbpt_front #(
  parameter int PageCount = tlbpt_pkg::PageCount
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [tlbpt_pkg::VaWidth-1:0]      virtual_address_i,
  input  wire logic [tlbpt_pkg::FrameWidth-1:0]   victim_frame_i,
  output logic                                    req_valid_o,
  input  wire logic                               req_take_i,
  output tlbpt_pkg::req_t                         req_o
);
  tlbpt_pkg::req_t q_mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  tlbpt_pkg::req_t in_req;
  logic push, pop;
  logic [tlbpt_pkg::PageWidth-1:0] pg_raw;

  // Page number reduced modulo the page count by shifted compare and subtract.
  always_comb begin
    logic [15:0] pr;
    pg_raw = virtual_address_i[tlbpt_pkg::VaWidth-1 -: tlbpt_pkg::PageWidth];
    pr = 16'(pg_raw);
    for (int k = 7; k >= 0; k--) begin
      if (pr >= (16'(PageCount) << k)) pr = pr - (16'(PageCount) << k);
    end
    in_req.page = pr[tlbpt_pkg::PageWidth-1:0];
    in_req.offset = virtual_address_i[tlbpt_pkg::OffWidth-1:0];
    in_req.victim = victim_frame_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_valid_o && req_take_i;
  assign req_o       = q_mem_q[rd_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_q] <= in_req;
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("queue lost an item");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

### rtl/core/tlbpt_back.sv
`default_nettype none
// Translates one request at a time: TLB search, page-table read, fault handling.
module tlbpt_back #(
  parameter int TlbEntries = tlbpt_pkg::TlbEntries,
  parameter int FrameCount = tlbpt_pkg::FrameCount,
  parameter int PageCount  = tlbpt_pkg::PageCount
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              req_valid_i,
  output logic                                   req_take_o,
  input  wire tlbpt_pkg::req_t                   req_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [tlbpt_pkg::PaWidth-1:0]          physical_address_o,
  output logic                                   tlb_hit_o,
  output logic                                   page_fault_o,
  output logic                                   evicted_o,
  output logic [tlbpt_pkg::PageWidth-1:0]        evicted_page_o
);
  localparam int FrameLimit = (FrameCount < 128) ? FrameCount : 128;
  localparam int TlbBits    = (TlbEntries > 1) ? $clog2(TlbEntries) : 1;
  localparam int FillBits   = $clog2(TlbEntries + 1);
  localparam int FrBits     = (FrameLimit > 1) ? $clog2(FrameLimit) : 1;
  localparam int PgBits     = (PageCount > 1) ? $clog2(PageCount) : 1;
  localparam int FW         = tlbpt_pkg::FrameWidth;
  localparam int PW         = tlbpt_pkg::PageWidth;

  tlbpt_pkg::be_state_e state_q, state_d;
  tlbpt_pkg::req_t      cur_q;

  // Page table and frame owner memories.
  logic [FW-1:0] pt_mem [PageCount];
  logic [PW-1:0] own_mem [FrameLimit];
  logic [FW-1:0] pt_rd_q;
  logic [PW-1:0] own_rd_q;
  logic [PageCount-1:0]  pvalid_q, pvalid_d;
  logic [FrameLimit-1:0] busy_q;

  // TLB entries kept in registers.
  logic [PW-1:0]         tpage_q [TlbEntries];
  logic [FW-1:0]         tframe_q [TlbEntries];
  logic [TlbEntries-1:0] tvalid_q, tvalid_d;
  logic [TlbBits-1:0]    head_q;
  logic [FillBits-1:0]   fill_q;

  // Result register.
  logic [FW-1:0] res_frame_q;
  logic          res_hit_q, res_fault_q, res_ev_q;
  logic [PW-1:0] res_evp_q;

  // Registered search results.
  logic          hit_q;
  logic [FW-1:0] hit_frame_q;
  logic          any_free_q;
  logic [FrBits-1:0] free_idx_q;

  logic          hit_c;
  logic [FW-1:0] hit_frame_c;
  logic          any_free_c;
  logic [FrBits-1:0] free_idx_c;
  logic [FrBits-1:0] vict_red;
  logic [FrBits-1:0] flt_frame;
  logic          flt_busy;
  logic [PgBits-1:0] cur_pg;
  logic [TlbBits-1:0] push_slot;
  logic [TlbBits+1:0] slot_sum;
  logic do_fault, do_own_rd;
  logic [FrBits-1:0] own_rd_idx;

  assign cur_pg = cur_q.page[PgBits-1:0];

  // Oldest valid matching TLB entry, searched in age order.
  always_comb begin
    logic [TlbBits+1:0] s;
    hit_c = 1'b0;
    hit_frame_c = '0;
    for (int i = TlbEntries - 1; i >= 0; i--) begin
      s = (TlbBits+2)'(head_q) + (TlbBits+2)'(i);
      if (s >= (TlbBits+2)'(TlbEntries)) s = s - (TlbBits+2)'(TlbEntries);
      if ((FillBits+1)'(i) < (FillBits+1)'(fill_q) && tvalid_q[s[TlbBits-1:0]] &&
          tpage_q[s[TlbBits-1:0]] == cur_q.page) begin
        hit_c = 1'b1;
        hit_frame_c = tframe_q[s[TlbBits-1:0]];
      end
    end
  end

  // Lowest free frame.
  always_comb begin
    any_free_c = 1'b0;
    free_idx_c = '0;
    for (int i = FrameLimit - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        any_free_c = 1'b1;
        free_idx_c = FrBits'(i);
      end
    end
  end

  // Victim reduced modulo the usable frame count by shifted compare and subtract.
  always_comb begin
    logic [15:0] v;
    v = 16'(cur_q.victim);
    for (int k = FW; k >= 0; k--) begin
      if (v >= (16'(FrameLimit) << k)) v = v - (16'(FrameLimit) << k);
    end
    vict_red = v[FrBits-1:0];
  end

  assign flt_frame = any_free_q ? free_idx_q : vict_red;
  assign flt_busy  = busy_q[flt_frame];
  assign do_fault  = (state_q == tlbpt_pkg::BeResolve) && !hit_q && !pvalid_q[cur_pg];
  assign own_rd_idx = (state_q == tlbpt_pkg::BeRead) ? vict_red : flt_frame;
  assign do_own_rd = 1'b1;

  assign slot_sum = (TlbBits+2)'(head_q) + (TlbBits+2)'(fill_q);
  assign push_slot = (fill_q < FillBits'(TlbEntries)) ?
    ((slot_sum >= (TlbBits+2)'(TlbEntries)) ?
     TlbBits'(slot_sum - (TlbBits+2)'(TlbEntries)) : slot_sum[TlbBits-1:0]) : head_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlbpt_pkg::BeIdle:    if (req_valid_i) state_d = tlbpt_pkg::BeRead;
      tlbpt_pkg::BeRead:    state_d = tlbpt_pkg::BeResolve;
      tlbpt_pkg::BeResolve: state_d = tlbpt_pkg::BeOut;
      tlbpt_pkg::BeOut:     if (!out_stall_i) state_d = tlbpt_pkg::BeIdle;
      default:              state_d = tlbpt_pkg::BeIdle;
    endcase
  end

  // Output logic.
  always_comb begin
    req_take_o  = (state_q == tlbpt_pkg::BeIdle);
    out_valid_o = (state_q == tlbpt_pkg::BeOut);
  end

  assign physical_address_o = {res_frame_q, cur_q.offset};
  assign tlb_hit_o      = res_hit_q;
  assign page_fault_o   = res_fault_q;
  assign evicted_o      = res_ev_q;
  assign evicted_page_o = res_evp_q;

  // Memory ports: page table and owner table.
  always_ff @(posedge clk_i) begin
    if (state_q == tlbpt_pkg::BeRead) pt_rd_q <= pt_mem[cur_pg];
    if (do_own_rd) own_rd_q <= own_mem[own_rd_idx];
    if (do_fault) begin
      pt_mem[cur_pg] <= FW'(flt_frame);
      own_mem[flt_frame] <= cur_q.page;
    end
  end

  // Request capture and search registers.
  always_ff @(posedge clk_i) begin
    if (req_take_o && req_valid_i) cur_q <= req_i;
    if (state_q == tlbpt_pkg::BeRead) begin
      hit_q <= hit_c; hit_frame_q <= hit_frame_c;
      any_free_q <= any_free_c; free_idx_q <= free_idx_c;
    end
    if (state_q == tlbpt_pkg::BeResolve) begin
      res_hit_q <= hit_q;
      res_fault_q <= do_fault;
      res_ev_q <= do_fault && flt_busy;
      res_evp_q <= (do_fault && flt_busy) ? own_rd_q : '0;
      res_frame_q <= hit_q ? hit_frame_q :
                     (!do_fault ? pt_rd_q : FW'(flt_frame));
    end
  end

  // TLB entry payload.
  always_ff @(posedge clk_i) begin
    if (do_fault) begin
      tpage_q[push_slot]  <= cur_q.page;
      tframe_q[push_slot] <= FW'(flt_frame);
    end
  end

  // Valid bits after a fault: unmap the old page, map the new one, drop stale
  // TLB entries for the frame and mark the pushed slot.
  always_comb begin
    pvalid_d = pvalid_q;
    tvalid_d = tvalid_q;
    if (do_fault) begin
      if (flt_busy) pvalid_d[own_rd_q[PgBits-1:0]] = 1'b0;
      pvalid_d[cur_pg] = 1'b1;
      for (int i = 0; i < TlbEntries; i++) begin
        if (tframe_q[i] == FW'(flt_frame)) tvalid_d[i] = 1'b0;
      end
      tvalid_d[push_slot] = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlbpt_pkg::BeIdle;
      pvalid_q <= '0; busy_q <= '0; tvalid_q <= '0;
      head_q <= '0; fill_q <= '0;
    end else begin
      state_q <= state_d;
      pvalid_q <= pvalid_d;
      tvalid_q <= tvalid_d;
      if (do_fault) begin
        busy_q[flt_frame] <= 1'b1;
        if (fill_q < FillBits'(TlbEntries)) fill_q <= fill_q + 1'b1;
        else head_q <= (head_q == TlbBits'(TlbEntries - 1)) ? '0 : head_q + 1'b1;
      end
    end
  end

  a_fault_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_fault |=> busy_q[$past(flt_frame)]) else $error("fault frame not marked busy");
  a_hit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tlb_hit_o && page_fault_o)) else $error("hit and fault together");
  a_ev_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_o) |-> page_fault_o) else $error("eviction without fault");
endmodule
`default_nettype wire

### rtl/core/tlb_page_table_translator.sv
`default_nettype none
// Virtual-to-physical translator with a FIFO TLB and a page table. An accepted
// item waits in a two-entry queue; the back end then takes it through its steps
// (taking it from the queue, TLB search with the page-table read, resolve,
// output) and takes no new item until the current one has left the output.
// Output stalls lengthen the output step while the queue still takes up to two items.
// A fault picks the lowest free frame or the victim_frame_i input, evicts its
// old page and pushes the new mapping.
module tlb_page_table_translator #(
  parameter int TlbEntries = tlbpt_pkg::TlbEntries,
  parameter int FrameCount = tlbpt_pkg::FrameCount,
  parameter int PageCount  = tlbpt_pkg::PageCount
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [tlbpt_pkg::VaWidth-1:0]     virtual_address_i,
  input  wire logic [tlbpt_pkg::FrameWidth-1:0]  victim_frame_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [tlbpt_pkg::PaWidth-1:0]          physical_address_o,
  output logic                                   tlb_hit_o,
  output logic                                   page_fault_o,
  output logic                                   evicted_o,
  output logic [tlbpt_pkg::PageWidth-1:0]        evicted_page_o
);
  logic req_valid, req_take;
  tlbpt_pkg::req_t req;

  tlbpt_front #(.PageCount(PageCount)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .virtual_address_i,
    .victim_frame_i, .req_valid_o(req_valid), .req_take_i(req_take), .req_o(req)
  );

  tlbpt_back #(.TlbEntries(TlbEntries), .FrameCount(FrameCount),
    .PageCount(PageCount)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_take_o(req_take), .req_i(req),
    .out_valid_o, .out_stall_i, .physical_address_o, .tlb_hit_o, .page_fault_o,
    .evicted_o, .evicted_page_o
  );
endmodule
`default_nettype wire
